// ===== hdl/accumulated_radiance_to_rgba8_macros.svh =====
// Assertion helpers used by the top-level RTL file.
// Each macro expects clk and rst_n in scope.
`ifndef ACCUMULATED_RADIANCE_TO_RGBA8_MACROS_SVH
`define ACCUMULATED_RADIANCE_TO_RGBA8_MACROS_SVH

// Same-cycle implication.
`define AR2R_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ar2r assertion failed");

// Next-cycle implication.
`define AR2R_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ar2r assertion failed");

`endif

// ===== hdl/ar2r_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ar2r_pkg;
  localparam int FRAC_BITS = 16;
  localparam int MAX_TILE  = 256;
  localparam int SUM_W     = 32;
  localparam int CNT_W     = 16;
  localparam int TILE_W    = 9;
  localparam int COORD_W   = 8;
  localparam int BYTE_W    = 8;
  localparam int IDX_W     = 8;
  localparam int DATA_W    = 16;
  localparam int SQ_W      = 16;
  localparam int ROOT_W    = 8;
  // input reg, one stage per quotient bit, multiply, one stage per root bit
  localparam int CHAN_LAT  = FRAC_BITS + ROOT_W + 2;

  localparam logic [SQ_W-1:0]   GAMMA_SCALE  = 16'd65025;
  localparam logic [BYTE_W-1:0] ALPHA_BYTE   = 8'hFF;
  localparam logic [SUM_W-1:0]  MARKER_PIXEL = 32'hFFFFFFFF;

  typedef enum logic [IDX_W-1:0] {
    REG_TILE_WIDTH    = 8'd0,
    REG_TILE_HEIGHT   = 8'd1,
    REG_SAMPLES_TAKEN = 8'd2,
    REG_SAMPLE_LIMIT  = 8'd3
  } cfg_reg_t;

  typedef struct packed {
    logic             en;
    logic [CNT_W-1:0] div;
  } chan_ctl_t;
endpackage
`default_nettype wire

// ===== hdl/ar2r_chan.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ar2r_chan (
  input  logic                         clk,
  input  ar2r_pkg::chan_ctl_t          ctl,
  input  logic [ar2r_pkg::SUM_W-1:0]   sum,
  output logic [ar2r_pkg::BYTE_W-1:0]  chan_byte
);
  import ar2r_pkg::*;

  localparam int HI_W   = SUM_W - FRAC_BITS;
  localparam int CMP_W  = (HI_W > CNT_W) ? HI_W : CNT_W;
  localparam int REM_W  = CNT_W;
  localparam int PROD_W = SQ_W + FRAC_BITS;
  localparam int SR_W   = ROOT_W + 2;

  logic [HI_W-1:0]      hi;
  logic                 sat0;
  logic [REM_W-1:0]     rem_r [0:FRAC_BITS-1];
  logic [FRAC_BITS-1:0] ql_r  [0:FRAC_BITS];
  logic                 sat_r [0:FRAC_BITS];
  logic [PROD_W-1:0]    prod;
  logic [SQ_W-1:0]      sqx_r   [0:ROOT_W-1];
  logic [SR_W-1:0]      sqrem_r [0:ROOT_W];
  logic [ROOT_W-1:0]    root_r  [0:ROOT_W];
  logic                 sqsat_r [0:ROOT_W];

  // Quotient saturates when the integer part already reaches the divisor.
  assign hi   = sum[SUM_W-1:FRAC_BITS];
  assign sat0 = CMP_W'(hi) >= CMP_W'(ctl.div);

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      rem_r[0] <= sat0 ? '0 : REM_W'(hi);
      ql_r[0]  <= sum[FRAC_BITS-1:0];
      sat_r[0] <= sat0;
    end
  end

  // Restoring division, one quotient bit per stage; the low sum bits shift
  // out of ql as quotient bits shift in.
  for (genvar k = 0; k < FRAC_BITS; k++) begin : g_div
    logic [REM_W:0] trial;
    logic [REM_W:0] diff;
    logic           ge;
    assign trial = {rem_r[k], ql_r[k][FRAC_BITS-1]};
    assign diff  = trial - {1'b0, ctl.div};
    assign ge    = trial >= {1'b0, ctl.div};
    always_ff @(posedge clk) begin
      if (ctl.en) begin
        ql_r[k+1]  <= {ql_r[k][FRAC_BITS-2:0], ge};
        sat_r[k+1] <= sat_r[k];
      end
    end
    if (k < FRAC_BITS - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (ctl.en) begin
          rem_r[k+1] <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
        end
      end
    end
  end

  // Scale by 255^2 and drop the fraction.
  assign prod = PROD_W'(GAMMA_SCALE) * PROD_W'(ql_r[FRAC_BITS]);

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      sqx_r[0]   <= prod[PROD_W-1:FRAC_BITS];
      sqrem_r[0] <= '0;
      root_r[0]  <= '0;
      sqsat_r[0] <= sat_r[FRAC_BITS];
    end
  end

  // Digit-by-digit square root, one root bit per stage.
  for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
    logic [SR_W+1:0] trial;
    logic [SR_W+1:0] tsub;
    logic [SR_W+1:0] diff;
    logic            ge;
    assign trial = {sqrem_r[j], sqx_r[j][SQ_W-1 -: 2]};
    assign tsub  = {2'b00, root_r[j], 2'b01};
    assign diff  = trial - tsub;
    assign ge    = trial >= tsub;
    always_ff @(posedge clk) begin
      if (ctl.en) begin
        sqrem_r[j+1] <= ge ? diff[SR_W-1:0] : trial[SR_W-1:0];
        root_r[j+1]  <= {root_r[j][ROOT_W-2:0], ge};
        sqsat_r[j+1] <= sqsat_r[j];
      end
    end
    if (j < ROOT_W - 1) begin : g_x
      always_ff @(posedge clk) begin
        if (ctl.en) begin
          sqx_r[j+1] <= {sqx_r[j][SQ_W-3:0], 2'b00};
        end
      end
    end
  end

  assign chan_byte = sqsat_r[ROOT_W] ? '1 : root_r[ROOT_W];
endmodule
`default_nettype wire

// ===== hdl/accumulated_radiance_to_rgba8.sv =====
// Pipeline from input accept to out_valid: 16 divide stages, one multiply
//   stage, 8 square-root stages, input and output registers.
// Throughput: one pixel word per cycle; the whole pipeline holds on out_stall.
// Reset (rst_n low, synchronous): clears all valid bits and loads tile 32x32,
//   samples_taken 1, sample_limit 64. Config writes are taken every cycle.
`timescale 1ns / 1ps
`default_nettype none
module accumulated_radiance_to_rgba8 (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ar2r_pkg::SUM_W-1:0]    in_red_sum,
  input  logic [ar2r_pkg::SUM_W-1:0]    in_green_sum,
  input  logic [ar2r_pkg::SUM_W-1:0]    in_blue_sum,
  input  logic [ar2r_pkg::COORD_W-1:0]  in_row,
  input  logic [ar2r_pkg::COORD_W-1:0]  in_col,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ar2r_pkg::SUM_W-1:0]    out_pixel,
  output logic                          out_is_marker,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ar2r_pkg::IDX_W-1:0]    cfg_index,
  input  logic [ar2r_pkg::DATA_W-1:0]   cfg_data
);
  import ar2r_pkg::*;
  `include "accumulated_radiance_to_rgba8_macros.svh"

  logic [TILE_W-1:0] tile_width_r, tile_height_r;
  logic [CNT_W-1:0]  samples_taken_r, sample_limit_r;

  logic              en;
  chan_ctl_t         ctl;
  logic [TILE_W-1:0] w, h, qw, qh, r9, c9;
  logic              row_end, col_end, row_band, col_band, bracket, mark_in;
  logic [BYTE_W-1:0] red_byte, green_byte, blue_byte;

  logic              vld_r [0:CHAN_LAT-1];
  logic              mk_r  [0:CHAN_LAT-1];
  logic              out_valid_r;
  logic [SUM_W-1:0]  out_pixel_r;
  logic              out_is_marker_r;

  // Configuration: always ready; unknown indexes drop the word.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_width_r    <= TILE_W'(32);
      tile_height_r   <= TILE_W'(32);
      samples_taken_r <= CNT_W'(1);
      sample_limit_r  <= CNT_W'(64);
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TILE_WIDTH:    tile_width_r    <= cfg_data[TILE_W-1:0];
        REG_TILE_HEIGHT:   tile_height_r   <= cfg_data[TILE_W-1:0];
        REG_SAMPLES_TAKEN: samples_taken_r <= cfg_data[CNT_W-1:0];
        REG_SAMPLE_LIMIT:  sample_limit_r  <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance everything unless a finished word is waiting on a stalled sink.
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // A zero sample count divides as one.
  assign ctl.en  = en;
  assign ctl.div = (samples_taken_r == '0) ? CNT_W'(1) : samples_taken_r;

  // Bracket test on the clamped tile size, done at entry.
  assign w  = (tile_width_r  > TILE_W'(MAX_TILE)) ? TILE_W'(MAX_TILE) : tile_width_r;
  assign h  = (tile_height_r > TILE_W'(MAX_TILE)) ? TILE_W'(MAX_TILE) : tile_height_r;
  assign qw = w >> 2;
  assign qh = h >> 2;
  assign r9 = {1'b0, in_row};
  assign c9 = {1'b0, in_col};

  assign col_end  = (c9 == '0) || (c9 == w - TILE_W'(1));
  assign row_end  = (r9 == '0) || (r9 == h - TILE_W'(1));
  assign row_band = (r9 < qh) || (r9 > h - qh);
  assign col_band = (c9 < qw) || (c9 > w - qw);
  assign bracket  = (w != '0) && (h != '0) && (r9 < h) && (c9 < w) &&
                    ((col_end && row_band) || (row_end && col_band));
  assign mark_in  = (samples_taken_r < sample_limit_r) && bracket;

  ar2r_chan u_red   (.clk(clk), .ctl(ctl), .sum(in_red_sum),   .chan_byte(red_byte));
  ar2r_chan u_green (.clk(clk), .ctl(ctl), .sum(in_green_sum), .chan_byte(green_byte));
  ar2r_chan u_blue  (.clk(clk), .ctl(ctl), .sum(in_blue_sum),  .chan_byte(blue_byte));

  // Valid and marker bits travel alongside the channel pipelines.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHAN_LAT; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < CHAN_LAT; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mk_r[0] <= mark_in;
      for (int i = 1; i < CHAN_LAT; i++) begin
        mk_r[i] <= mk_r[i-1];
      end
    end
  end

  // Output register: pack ABGR or substitute the white marker word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[CHAN_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_pixel_r     <= mk_r[CHAN_LAT-1] ? MARKER_PIXEL
                                          : {ALPHA_BYTE, blue_byte, green_byte, red_byte};
      out_is_marker_r <= mk_r[CHAN_LAT-1];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel     = out_pixel_r;
  assign out_is_marker = out_is_marker_r;

  `AR2R_ASSERT_IMP(a_marker_white, out_valid_r && out_is_marker_r, out_pixel_r == MARKER_PIXEL)
  `AR2R_ASSERT_IMP(a_alpha_opaque, out_valid_r, out_pixel_r[SUM_W-1 -: BYTE_W] == ALPHA_BYTE)
  `AR2R_ASSERT_NXT(a_pipe_hold, !en, vld_r[CHAN_LAT-1] == $past(vld_r[CHAN_LAT-1]))
  `AR2R_ASSERT_NXT(a_no_phantom, !out_valid_r && !vld_r[CHAN_LAT-1], !out_valid_r)
endmodule
`default_nettype wire

// ===== dv/tb_accumulated_radiance_to_rgba8.sv =====
`timescale 1ns / 1ps
module tb_accumulated_radiance_to_rgba8;
  import ar2r_pkg::*;

  // Any index past the last register; the block must drop the write.
  localparam logic [IDX_W-1:0] REG_UNUSED = 8'd4;
  localparam int LIMIT_CYCLES = 600000;
  // Pipeline depth from the top-level header plus margin.
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic [SUM_W-1:0] pixel;
    logic             is_marker;
  } pixel_word_t;

  // Scoreboard: shadow of the four registers plus the queue of pixels due.
  class pixel_scoreboard;
    logic [TILE_W-1:0] tile_w = 32;
    logic [TILE_W-1:0] tile_h = 32;
    logic [CNT_W-1:0]  samples = 1;
    logic [CNT_W-1:0]  limit = 64;
    pixel_word_t       pending[$];
    int                errors = 0;

    function void write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      case (idx)
        REG_TILE_WIDTH:    tile_w = data[TILE_W-1:0];
        REG_TILE_HEIGHT:   tile_h = data[TILE_W-1:0];
        REG_SAMPLES_TAKEN: samples = data;
        REG_SAMPLE_LIMIT:  limit = data;
        default: ;
      endcase
    endfunction

    function int unsigned int_root(int unsigned x);
      int unsigned res;
      int unsigned pw;
      res = 0;
      pw = 32'h4000_0000;
      while (pw > x) pw = pw >> 2;
      while (pw != 0) begin
        if (x >= res + pw) begin
          x = x - (res + pw);
          res = (res >> 1) + pw;
        end else begin
          res = res >> 1;
        end
        pw = pw >> 2;
      end
      return res;
    endfunction

    // Average the sum, then gamma-2 encode: floor(255 * sqrt(v / 2^16)).
    function logic [BYTE_W-1:0] gamma_byte(logic [SUM_W-1:0] sum);
      int unsigned div;
      int unsigned v;
      div = (samples == 0) ? 1 : samples;
      v = sum / div;
      if (v >= (1 << FRAC_BITS)) return 8'hFF;
      return BYTE_W'(int_root((65025 * v) >> FRAC_BITS));
    endfunction

    function bit bracket(int r, int c);
      int w;
      int h;
      w = (tile_w > MAX_TILE) ? MAX_TILE : tile_w;
      h = (tile_h > MAX_TILE) ? MAX_TILE : tile_h;
      if (w == 0 || h == 0 || r >= h || c >= w) return 0;
      if ((c == 0 || c == w - 1) && (r < h / 4 || r > h - h / 4)) return 1;
      if ((r == 0 || r == h - 1) && (c < w / 4 || c > w - w / 4)) return 1;
      return 0;
    endfunction

    function void note_pixel(logic [SUM_W-1:0] red, logic [SUM_W-1:0] green,
                             logic [SUM_W-1:0] blue, logic [COORD_W-1:0] row,
                             logic [COORD_W-1:0] col);
      pixel_word_t w;
      w.pixel = {ALPHA_BYTE, gamma_byte(blue), gamma_byte(green), gamma_byte(red)};
      w.is_marker = 0;
      if (samples < limit && bracket(row, col)) begin
        w.pixel = MARKER_PIXEL;
        w.is_marker = 1;
      end
      pending.push_back(w);
    endfunction

    task report(string what, logic [SUM_W-1:0] got, logic [SUM_W-1:0] want);
      $display("mismatch %s: got %h, want %h at %0t", what, got, want, $time);
      errors++;
    endtask

    task check_pixel(logic [SUM_W-1:0] pixel, logic is_marker);
      pixel_word_t w;
      if (pending.size() == 0) begin
        report("unexpected word", pixel, 0);
        return;
      end
      w = pending.pop_front();
      if (pixel !== w.pixel) report("pixel", pixel, w.pixel);
      if (is_marker !== w.is_marker) report("is_marker", is_marker, w.is_marker);
    endtask
  endclass

  logic                clk = 0;
  logic                rst_n = 0;
  logic                in_valid = 0;
  logic                in_stall;
  logic [SUM_W-1:0]    in_red_sum = 0;
  logic [SUM_W-1:0]    in_green_sum = 0;
  logic [SUM_W-1:0]    in_blue_sum = 0;
  logic [COORD_W-1:0]  in_row = 0;
  logic [COORD_W-1:0]  in_col = 0;
  logic                out_valid;
  logic                out_stall = 0;
  logic [SUM_W-1:0]    out_pixel;
  logic                out_is_marker;
  logic                cfg_valid = 0;
  logic                cfg_ready;
  logic [IDX_W-1:0]    cfg_index = 0;
  logic [DATA_W-1:0]   cfg_data = 0;

  pixel_scoreboard sb = new();
  bit quiet = 0;  // set for stretches with no idling on either side
  int cycles = 0;

  accumulated_radiance_to_rgba8 u_top (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Bound the run; a hung handshake lands here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Check every word the block hands over.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_pixel(out_pixel, out_is_marker);
  end

  // Receiver: stall a random number of cycles per word, then take one.
  initial begin
    int n;
    @(posedge clk iff rst_n);
    forever begin
      n = quiet ? 0 : $urandom_range(0, 8);
      if (n > 0) begin
        out_stall <= 1;
        repeat (n) @(posedge clk);
        out_stall <= 0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  // Drive one pixel word after a random gap; hold it until accepted.
  task send_pixel(logic [SUM_W-1:0] r, logic [SUM_W-1:0] g, logic [SUM_W-1:0] b,
                  logic [COORD_W-1:0] row, logic [COORD_W-1:0] col);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_red_sum <= r;
    in_green_sum <= g;
    in_blue_sum <= b;
    in_row <= row;
    in_col <= col;
    do @(posedge clk); while (in_stall);
    sb.note_pixel(r, g, b, row, col);
  endtask

  // Drain the pipeline so register writes land on an idle block.
  task wait_idle();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  task set_tile(int w, int h, int samples, int limit);
    wait_idle();
    write_reg(REG_TILE_WIDTH, DATA_W'(w));
    write_reg(REG_TILE_HEIGHT, DATA_W'(h));
    write_reg(REG_SAMPLES_TAKEN, DATA_W'(samples));
    write_reg(REG_SAMPLE_LIMIT, DATA_W'(limit));
  endtask

  // Sum biased toward the unsaturated range for the current divisor.
  function logic [SUM_W-1:0] rand_sum();
    longint top;
    top = (sb.samples == 0 ? 1 : sb.samples) * 64'd65536;
    if (top > 64'hFFFF_FFFF) top = 64'hFFFF_FFFF;
    case ($urandom_range(0, 5))
      0:       return $urandom();
      1:       return SUM_W'(top - longint'($urandom_range(0, 3)));
      default: return $urandom_range(0, SUM_W'(top - 1));
    endcase
  endfunction

  // Coordinates mostly inside the tile, weighted toward the first and last index, where the brackets live.
  function logic [COORD_W-1:0] rand_coord(int dim);
    int d;
    d = (dim > MAX_TILE) ? MAX_TILE : dim;
    if (d == 0) return COORD_W'($urandom_range(0, 255));
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return COORD_W'(d - 1);
      2:       return COORD_W'($urandom_range(0, 255));
      default: return COORD_W'($urandom_range(0, d - 1));
    endcase
  endfunction

  task random_pixels(int count);
    repeat (count) begin
      send_pixel(rand_sum(), rand_sum(), rand_sum(),
                 rand_coord(sb.tile_h), rand_coord(sb.tile_w));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Reset tile 32x32, one sample, brackets on: extremes and bracket edges.
    send_pixel(0, 0, 0, 1, 1);
    send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1);
    send_pixel(32'h0000_FFFF, 32'h0001_0000, 32'h0000_0001, 5, 5);
    send_pixel(32'h0000_4000, 32'h0000_8000, 32'h0000_C000, 5, 6);
    send_pixel(1, 2, 3, 0, 0);
    send_pixel(1, 2, 3, 0, 31);
    send_pixel(1, 2, 3, 31, 0);
    send_pixel(1, 2, 3, 31, 31);
    send_pixel(1, 2, 3, 7, 0);
    send_pixel(1, 2, 3, 8, 0);
    send_pixel(1, 2, 3, 24, 31);
    send_pixel(1, 2, 3, 25, 31);
    send_pixel(1, 2, 3, 0, 8);
    send_pixel(1, 2, 3, 31, 25);
    // Outside the tile: converted normally, never a bracket.
    send_pixel(1, 2, 3, 255, 0);
    send_pixel(1, 2, 3, 0, 255);

    // Zero samples act as one; empty tile draws no bracket.
    set_tile(0, 5, 0, 64);
    send_pixel(32'h0000_FFFF, 32'h0001_0000, 0, 0, 0);
    // Oversized tile saturates; limit of zero turns brackets off.
    set_tile(16'h01FF, 300, 3, 0);
    send_pixel(32'h0002_FFFF, 32'hFFFF_FFFF, 5, 0, 0);
    // Largest counts; writes with stray upper bits and an unused index.
    set_tile(16'hFFFF, 1, 16'hFFFF, 16'hFFFF);
    write_reg(REG_UNUSED, 16'h0001);
    send_pixel(32'hFFFF_FFFF, 32'hFFFE_FFFF, 32'h1234_5678, 0, 255);
    send_pixel(32'hFFFF_FFFF, 32'hFFFE_FFFF, 32'h1234_5678, 0, 0);
    set_tile(1, 1, 1, 2);
    send_pixel(7, 8, 9, 0, 0);
    send_pixel(7, 8, 9, 1, 0);

    // Random phases, each under its own tile setting.
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: set_tile(4, 4, 2, 65535);
        1: set_tile(256, 256, 65535, 65535);
        2: set_tile(1, 256, 1, 0);
        default: set_tile($urandom_range(0, 511),
                          $urandom_range(0, 511),
                          $urandom_range(0, 1) ? $urandom_range(0, 64)
                                               : $urandom_range(0, 65535),
                          $urandom_range(0, 128));
      endcase
      quiet = ($urandom_range(0, 3) == 0);
      random_pixels(190);
      quiet = 0;
    end

    wait_idle();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+hdl
hdl/ar2r_pkg.sv
hdl/ar2r_chan.sv
hdl/accumulated_radiance_to_rgba8.sv
dv/tb_accumulated_radiance_to_rgba8.sv
